/* sv/rsst_pkg.sv */
// Shared types and constants for the range-sum segment tree.
// Depends on nothing; every other file of the block but rsst_ram imports it.
package rsst_pkg;

	// Fixed field widths of the request and response channels
	localparam int unsigned LEAF_IDX_W = 10;
	localparam int unsigned DELTA_W    = 32;
	localparam int unsigned SUM_W      = 32;

	// Command codes carried in the request
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_QFIRST,
		ST_QLOOP,
		ST_DONE
	} rsst_state_t;

	// What the read issued in the previous cycle was for
	typedef enum logic [1:0] {
		RD_NONE,
		RD_ADD,
		RD_QFIRST,
		RD_QSTEP
	} rsst_rd_kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic clr;
		logic add_step;
		logic qry_first;
		logic qry_step;
		logic out_load;
	} rsst_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic node_zero;
		logic qry_more;
		logic inv_range;
	} rsst_stat_t;

endpackage

/* sv/rsst_req_if.sv */
// Request channel: valid/ready handshake with the add/query payload.
// Depends on rsst_pkg for the field widths.
interface rsst_req_if import rsst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [LEAF_IDX_W-1:0] leaf_index;
	logic signed [DELTA_W-1:0] delta;
	logic [LEAF_IDX_W-1:0] range_first;
	logic [LEAF_IDX_W-1:0] range_last;

	modport source (
		output valid, cmd, leaf_index, delta, range_first, range_last,
		input  ready
	);
	modport sink (
		input  valid, cmd, leaf_index, delta, range_first, range_last,
		output ready
	);
endinterface

/* sv/rsst_rsp_if.sv */
// Response channel: valid/ready handshake with the range sum and error flag.
// Depends on rsst_pkg for the field widths.
interface rsst_rsp_if import rsst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] range_sum;
	logic                    range_error;

	modport source (
		output valid, range_sum, range_error,
		input  ready
	);
	modport sink (
		input  valid, range_sum, range_error,
		output ready
	);
endinterface

/* sv/range_sum_segment_tree.sv */
// Range-sum segment tree with point add: top level joining controller and datapath.
// Depends on rsst_pkg, rsst_req_if, rsst_rsp_if, rsst_ctrl and rsst_dp.
//
// Usage:
//   req carries one command per transaction. An add (cmd = 0) adds delta to
//   leaf leaf_index and all its ancestors and gives no response. A query
//   (cmd = 1) gives one rsp transaction with the wrapped sum of leaves
//   range_first..range_last, or range_error = 1 and a zero sum when first
//   exceeds last. Leaf positions are masked to the tree size.
//   Items are handled one at a time. An add climbs from its leaf to the root,
//   one node read-modify-write per tree level, overlapped so each level costs
//   a single cycle of the node RAM. A query climbs from both range ends, one
//   level per cycle using both read ports of the node RAM, and then loads its
//   response into the output register; an inverted range skips the climb and
//   goes from acceptance to the done state, which loads the output register.
//   After arst_n is released the whole node store is swept to zero; req.ready
//   stays low until the sweep ends.
//   A response waits in the output register while rsp.ready is low; the
//   block takes no new request until that response can be loaded.
module range_sum_segment_tree import rsst_pkg::*; #(
	parameter int unsigned LEAVES     = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rsst_req_if.sink   req,
	rsst_rsp_if.source rsp
);
	rsst_cmd_t  cmd;
	rsst_stat_t stat;

	rsst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rsst_dp #(
		.LEAVES     (LEAVES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_cmd      (req.cmd),
		.leaf_index  (req.leaf_index),
		.delta       (req.delta),
		.range_first (req.range_first),
		.range_last  (req.range_last),
		.range_sum   (rsp.range_sum),
		.range_error (rsp.range_error)
	);
endmodule

/* sv/rsst_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Self-contained; no package needed.
module rsst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

/* sv/rsst_dp.sv */
// Datapath of the segment tree: node store, climb addresses, accumulator
// and output register. Depends on rsst_pkg and rsst_ram.
module rsst_dp import rsst_pkg::*; #(
	parameter int unsigned LEAVES     = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rsst_cmd_t                 cmd,
	output rsst_stat_t                stat,
	input  logic                      in_cmd,
	input  logic [LEAF_IDX_W-1:0]     leaf_index,
	input  logic signed [DELTA_W-1:0] delta,
	input  logic [LEAF_IDX_W-1:0]     range_first,
	input  logic [LEAF_IDX_W-1:0]     range_last,
	output logic signed [SUM_W-1:0]   range_sum,
	output logic                      range_error
);
	localparam int unsigned LEAF_W = $clog2(LEAVES);
	localparam int unsigned NODE_W = LEAF_W + 1;

	logic [LEAF_W-1:0]     leaf;
	logic [LEAF_W-1:0]     first;
	logic [LEAF_W-1:0]     last;
	logic [NODE_W-1:0]     node_q;
	logic [NODE_W-1:0]     lo_q;
	logic [NODE_W-1:0]     hi_q;
	logic [NODE_W-1:0]     lo_inc;
	logic [NODE_W-1:0]     hi_dec;
	logic [NODE_W-1:0]     clr_q;
	logic [DATA_WIDTH-1:0] delta_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  err_q;
	rsst_rd_kind_t         rd_kind_s1;
	logic [NODE_W-1:0]     wr_addr_s1;
	logic                  same_s1;
	logic                  add_lo_s1;
	logic                  add_hi_s1;
	logic                  we;
	logic [NODE_W-1:0]     waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [NODE_W-1:0]     raddr_a;
	logic [NODE_W-1:0]     raddr_b;
	logic [DATA_WIDTH-1:0] rdata_a;
	logic [DATA_WIDTH-1:0] rdata_b;
	logic [DATA_WIDTH-1:0] term_a;
	logic [DATA_WIDTH-1:0] term_b;

	// Mask leaf positions to the tree size
	assign leaf   = LEAF_W'(leaf_index);
	assign first  = LEAF_W'(range_first);
	assign last   = LEAF_W'(range_last);
	assign lo_inc = lo_q + NODE_W'(1);
	assign hi_dec = hi_q - NODE_W'(1);

	// Status toward the controller
	assign stat.clr_last  = (clr_q == {NODE_W{1'b1}});
	assign stat.node_zero = (node_q == '0);
	assign stat.qry_more  = (lo_inc != hi_q) && (lo_q < hi_q);
	assign stat.inv_range = (first > last);

	// Select read addresses for the current command
	always_comb begin
		if (cmd.add_step) begin
			raddr_a = node_q;
			raddr_b = node_q;
		end else if (cmd.qry_first) begin
			raddr_a = lo_q;
			raddr_b = hi_q;
		end else begin
			raddr_a = lo_inc;
			raddr_b = hi_dec;
		end
	end

	// Write back the updated node, or sweep zeros after reset
	always_comb begin
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = (rd_kind_s1 == RD_ADD);
			waddr = wr_addr_s1;
			wdata = rdata_a + delta_q;
		end
	end

	rsst_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (2 * LEAVES)
	) u_nodes (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + NODE_W'(1);
		end
	end

	// Track what the outstanding read belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_kind_s1 <= RD_NONE;
		end else if (cmd.add_step) begin
			rd_kind_s1 <= RD_ADD;
		end else if (cmd.qry_first) begin
			rd_kind_s1 <= RD_QFIRST;
		end else if (cmd.qry_step) begin
			rd_kind_s1 <= RD_QSTEP;
		end else begin
			rd_kind_s1 <= RD_NONE;
		end
	end

	// Read-side payload that travels with the outstanding read
	always_ff @(posedge clk) begin
		wr_addr_s1 <= node_q;
		same_s1    <= (lo_q == hi_q);
		add_lo_s1  <= ~lo_q[0];
		add_hi_s1  <= hi_q[0];
	end

	// Capture the item, then climb one level per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q  <= {1'b1, leaf};
			lo_q    <= {1'b1, first};
			hi_q    <= {1'b1, last};
			delta_q <= DATA_WIDTH'(delta);
			err_q   <= (in_cmd == CMD_QUERY) && (first > last);
		end else begin
			if (cmd.add_step) begin
				node_q <= node_q >> 1;
			end
			if (cmd.qry_step) begin
				lo_q <= lo_q >> 1;
				hi_q <= hi_q >> 1;
			end
		end
	end

	// Accumulate the range end nodes, then the sibling subtrees, returned by the last read
	assign term_a = add_lo_s1 ? rdata_a : '0;
	assign term_b = add_hi_s1 ? rdata_b : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else begin
			unique case (rd_kind_s1)
				RD_QFIRST: acc_q <= same_s1 ? rdata_a : rdata_a + rdata_b;
				RD_QSTEP:  acc_q <= acc_q + term_a + term_b;
				default:   acc_q <= acc_q;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_sum   <= SUM_W'(acc_q);
			range_error <= err_q;
		end
	end
endmodule

/* sv/rsst_ctrl.sv */
// Controller of the segment tree: sequences the clear sweep, add climb and
// query climb, and owns the handshakes. Depends on rsst_pkg.
module rsst_ctrl import rsst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_cmd,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsst_cmd_t  cmd,
	input  rsst_stat_t stat
);
	rsst_state_t state_q;
	rsst_state_t state_d;
	logic        out_valid_q;
	logic        accept;
	logic        out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_cmd == CMD_ADD) begin
						state_d = ST_ADD;
					end else if (stat.inv_range) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_QFIRST;
					end
				end
			end
			ST_ADD: begin
				if (stat.node_zero) state_d = ST_IDLE;
			end
			ST_QFIRST: state_d = ST_QLOOP;
			ST_QLOOP: begin
				if (!stat.qry_more) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.clr       = (state_q == ST_CLEAR);
		cmd.add_step  = (state_q == ST_ADD) && !stat.node_zero;
		cmd.qry_first = (state_q == ST_QFIRST);
		cmd.qry_step  = (state_q == ST_QLOOP) && stat.qry_more;
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

/* verif/rsst_sum_checker.sv */
// Scoreboard for range_sum_segment_tree: watches both channels, predicts each answer, compares.
// Depends on rsst_pkg and the rsst_req_if / rsst_rsp_if interfaces.
module rsst_sum_checker import rsst_pkg::*; #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	rsst_req_if  req,
	rsst_rsp_if  rsp,
	output int   fail_count,
	output int   sums_pending,
	output int   adds_seen,
	output int   queries_seen,
	output int   inverted_seen
);
	localparam int unsigned NODES = 2 * LEAVES;

	typedef struct {
		logic [SUM_W-1:0]      range_sum;
		logic                  range_error;
		logic [LEAF_IDX_W-1:0] range_first;
		logic [LEAF_IDX_W-1:0] range_last;
	} range_answer_t;

	// Model copy of the node store, heap order, root at 1, leaves at LEAVES
	logic [SUM_W-1:0] tree_sums [NODES];
	range_answer_t    answers_due [$];

	// Add the amount to the leaf and to every node on its way to the root
	function automatic void add_along_path(input logic [LEAF_IDX_W-1:0] leaf,
			input logic [SUM_W-1:0] amount);
		int unsigned node;
		node = LEAVES + (32'(leaf) % LEAVES);
		while (node != 0) begin
			tree_sums[node] = tree_sums[node] + amount;
			node = node >> 1;
		end
	endfunction

	// Climb from both ends of the inclusive range, picking up the inner siblings
	function automatic logic [SUM_W-1:0] sum_between(input int unsigned first_leaf,
			input int unsigned last_leaf);
		int unsigned      lo;
		int unsigned      hi;
		logic [SUM_W-1:0] acc;
		lo = LEAVES + first_leaf;
		hi = LEAVES + last_leaf;
		if (lo == hi)
			return tree_sums[lo];
		acc = tree_sums[lo] + tree_sums[hi];
		while (lo + 1 != hi && lo < hi) begin
			if (lo % 2 == 0)
				acc = acc + tree_sums[lo + 1];
			if (hi % 2 == 1)
				acc = acc + tree_sums[hi - 1];
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		range_answer_t want;
		int            bad;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				tree_sums[i] = '0;
			answers_due.delete();
			fail_count    <= 0;
			sums_pending  <= 0;
			adds_seen     <= 0;
			queries_seen  <= 0;
			inverted_seen <= 0;
		end else begin
			bad = 0;
			// Retire the oldest expected answer against each response transaction
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected response: expected none, got sum %0d error %0b",
						$time, rsp.range_sum, rsp.range_error);
					bad++;
				end else begin
					want = answers_due.pop_front();
					if (rsp.range_sum !== want.range_sum) begin
						$display("%0t: range_sum mismatch for [%0d..%0d]: expected %0d, got %0d",
							$time, want.range_first, want.range_last,
							$signed(want.range_sum), rsp.range_sum);
						bad++;
					end
					if (rsp.range_error !== want.range_error) begin
						$display("%0t: range_error mismatch for [%0d..%0d]: expected %0b, got %0b",
							$time, want.range_first, want.range_last,
							want.range_error, rsp.range_error);
						bad++;
					end
				end
			end
			// Update the model tree on an add, queue the answer on a query
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_ADD) begin
					add_along_path(req.leaf_index, req.delta);
					adds_seen <= adds_seen + 1;
				end else begin
					want.range_first = req.range_first;
					want.range_last  = req.range_last;
					if (req.range_first > req.range_last) begin
						want.range_sum   = '0;
						want.range_error = 1'b1;
						inverted_seen <= inverted_seen + 1;
					end else begin
						want.range_sum   = sum_between(32'(req.range_first), 32'(req.range_last));
						want.range_error = 1'b0;
					end
					answers_due.push_back(want);
					queries_seen <= queries_seen + 1;
				end
			end
			fail_count   <= fail_count + bad;
			sums_pending <= answers_due.size();
		end
	end

endmodule

/* verif/range_sum_segment_tree_test.sv */
// Testbench top for range_sum_segment_tree: clock, reset, request stimulus and response stalls.
// Depends on rsst_pkg, rsst_req_if, rsst_rsp_if, the block itself and rsst_sum_checker.
module range_sum_segment_tree_test;
	import rsst_pkg::*;

	localparam int unsigned TREE_LEAVES   = 1 << LEAF_IDX_W;
	localparam int unsigned RANDOM_ITEMS  = 1500;
	localparam int unsigned CALM_EVERY    = 250;
	localparam int unsigned SETTLE_CYCLES = 2 * LEAF_IDX_W + 8;
	localparam int unsigned IDLE_LIMIT    = 20000;

	typedef struct packed {
		logic                      cmd;
		logic [LEAF_IDX_W-1:0]     leaf_index;
		logic signed [DELTA_W-1:0] delta;
		logic [LEAF_IDX_W-1:0]     range_first;
		logic [LEAF_IDX_W-1:0]     range_last;
	} tree_request_t;

	typedef enum logic [1:0] {
		DRAIN_OPEN,
		DRAIN_COIN,
		DRAIN_SLOW,
		DRAIN_BLOCKED
	} drain_mode_t;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          req_valid   = 1'b0;
	tree_request_t req_item    = '0;
	logic          drain_ready = 1'b0;
	drain_mode_t   drain_mode  = DRAIN_OPEN;
	int            mode_left   = 0;
	int            burst_left  = 0;
	int            idle_cycles = 0;
	int            fail_count;
	int            sums_pending;
	int            adds_seen;
	int            queries_seen;
	int            inverted_seen;

	rsst_req_if req_ch ();
	rsst_rsp_if rsp_ch ();

	assign req_ch.valid       = req_valid;
	assign req_ch.cmd         = req_item.cmd;
	assign req_ch.leaf_index  = req_item.leaf_index;
	assign req_ch.delta       = req_item.delta;
	assign req_ch.range_first = req_item.range_first;
	assign req_ch.range_last  = req_item.range_last;
	assign rsp_ch.ready       = drain_ready;

	range_sum_segment_tree #(
		.LEAVES     (TREE_LEAVES),
		.DATA_WIDTH (SUM_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rsst_sum_checker #(
		.LEAVES (TREE_LEAVES)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.sums_pending  (sums_pending),
		.adds_seen     (adds_seen),
		.queries_seen  (queries_seen),
		.inverted_seen (inverted_seen)
	);

	always #2 clk = ~clk;

	// Stall the response side on a pattern drawn anew whenever the current mode runs out
	always @(posedge clk) begin
		if (!arst_n) begin
			drain_ready <= 1'b0;
		end else if (mode_left == 0) begin
			drain_mode  <= drain_mode_t'($urandom_range(0, 3));
			mode_left   <= $urandom_range(20, 300);
			drain_ready <= 1'b1;
		end else begin
			mode_left <= mode_left - 1;
			case (drain_mode)
				DRAIN_OPEN: begin
					drain_ready <= 1'b1;
				end
				DRAIN_COIN: begin
					drain_ready <= 1'($urandom_range(0, 1));
				end
				DRAIN_SLOW: begin
					drain_ready <= ($urandom_range(0, 5) == 0);
				end
				default: begin
					drain_ready <= (mode_left % 40 == 0);
				end
			endcase
		end
	end

	// End the run when no transaction moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("range_sum_segment_tree regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic tree_request_t make_add(input int unsigned leaf,
			input logic [DELTA_W-1:0] amount);
		tree_request_t r;
		r.cmd         = CMD_ADD;
		r.leaf_index  = LEAF_IDX_W'(leaf);
		r.delta       = amount;
		// Unused fields carry noise
		r.range_first = LEAF_IDX_W'($urandom);
		r.range_last  = LEAF_IDX_W'($urandom);
		return r;
	endfunction

	function automatic tree_request_t make_query(input int unsigned first_leaf,
			input int unsigned last_leaf);
		tree_request_t r;
		r.cmd         = CMD_QUERY;
		r.leaf_index  = LEAF_IDX_W'($urandom);
		r.delta       = $urandom;
		r.range_first = LEAF_IDX_W'(first_leaf);
		r.range_last  = LEAF_IDX_W'(last_leaf);
		return r;
	endfunction

	// Half adds, half queries; both lean toward a hot window so sums stay interesting
	function automatic tree_request_t random_request(input int unsigned hot_base);
		int unsigned        a;
		int unsigned        b;
		int unsigned        c;
		int unsigned        pick;
		logic [DELTA_W-1:0] amount;
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 1) == 0) begin
			if (pick < 5)
				amount = $urandom_range(0, 400) - 200;
			else if (pick == 5)
				amount = {1'b0, {(DELTA_W-1){1'b1}}};
			else if (pick == 6)
				amount = {1'b1, {(DELTA_W-1){1'b0}}};
			else
				amount = $urandom;
			a = ($urandom_range(0, 1) == 0) ? hot_base + $urandom_range(0, 31) : $urandom;
			return make_add(a % TREE_LEAVES, amount);
		end
		a = $urandom_range(0, TREE_LEAVES - 1);
		b = $urandom_range(0, TREE_LEAVES - 1);
		case (pick)
			0: begin
				a = $urandom_range(1, TREE_LEAVES - 1);
				return make_query(a, $urandom_range(0, a - 1));
			end
			1: begin
				return make_query(a, a);
			end
			2: begin
				if ($urandom_range(0, 1) == 0)
					return make_query(0, b);
				return make_query(a, TREE_LEAVES - 1);
			end
			3, 4, 5: begin
				a = hot_base;
				b = (hot_base + $urandom_range(0, 40)) % TREE_LEAVES;
			end
			default: begin
			end
		endcase
		if (a > b) begin
			c = a;
			a = b;
			b = c;
		end
		return make_query(a, b);
	endfunction

	task automatic send_request(input tree_request_t r);
		int gap;
		// Open a new burst, usually after a gap, sometimes back to back
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_item  <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Hold off the sender until every outstanding query has been answered
	task automatic wait_for_answers();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sums_pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned hot_base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty tree, delta extremes, wrapping sums, edge and inverted ranges
		send_request(make_query(0, TREE_LEAVES - 1));
		send_request(make_add(0, 32'h7fff_ffff));
		send_request(make_add(TREE_LEAVES - 1, 32'h8000_0000));
		send_request(make_add(TREE_LEAVES / 2, 32'hffff_ffff));
		send_request(make_add(TREE_LEAVES / 2 - 1, 32'h0000_0001));
		send_request(make_add(10'h2aa, 32'h5555_5555));
		send_request(make_add(10'h155, 32'haaaa_aaaa));
		send_request(make_query(0, TREE_LEAVES - 1));
		send_request(make_query(0, 0));
		send_request(make_query(TREE_LEAVES - 1, TREE_LEAVES - 1));
		send_request(make_query(TREE_LEAVES / 2 - 1, TREE_LEAVES / 2));
		send_request(make_query(TREE_LEAVES - 1, 0));
		send_request(make_query(1, 0));
		send_request(make_query(TREE_LEAVES / 2 + 1, TREE_LEAVES / 2));
		send_request(make_query(0, TREE_LEAVES - 2));
		send_request(make_query(1, TREE_LEAVES - 1));
		send_request(make_add(0, 32'h8000_0001));
		send_request(make_query(0, 0));
		send_request(make_query(10'h155, 10'h2aa));
		send_request(make_query(0, TREE_LEAVES / 2 - 1));
		send_request(make_query(TREE_LEAVES / 2, TREE_LEAVES - 1));
		wait_for_answers();

		// Random traffic, moving the hot window now and then, draining between phases
		hot_base = $urandom_range(0, TREE_LEAVES - 1);
		for (int n = 1; n <= RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				hot_base = $urandom_range(0, TREE_LEAVES - 1);
			send_request(random_request(hot_base));
			if (n % CALM_EVERY == 0)
				wait_for_answers();
		end
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d queries (%0d with first past last) against %0d leaf adds,",
			queries_seen, inverted_seen, adds_seen);
		$display("under bursty requests, a stalling response side and full drains between phases.");
		if (fail_count == 0)
			$display("range_sum_segment_tree regression: pass");
		else
			$display("range_sum_segment_tree regression: fail");
		$finish;
	end

endmodule
